### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and gated by an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// types and codes for the indexed list store
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

  // list depth; position and count widths follow from it
  localparam int DEPTH  = 256;

  localparam int ACT_W  = 3;
  localparam int POS_W  = $clog2(DEPTH);
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = POS_W + 1;

  localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_EDIT     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_GET      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FIND     = 3'd5;
  // spare codes, taken and ignored
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADINDEX = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_PLACE,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

### sv/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/indexed_list_store_top.sv
// ----------------------------------------------------------------------------
// indexed_list_store_top
// bounded packed list of words in one RAM: append, insert, edit, delete, get, find
// ----------------------------------------------------------------------------
// append, edit, rejected actions: out_valid is registered from the execute state; get also passes the read state
// insert walks from the last entry down to the position, then places the word; delete walks up from the position
// find walks up from entry zero and stops at the first hit or at the end of the list
// insert, delete and find walk the RAM one entry a cycle
// busy drops in the cycle that carries out_valid, so the next start is taken there
// reset clears the count and sets capacity to 256; RAM contents are not cleared
`default_nettype none
`include "assert_macros.svh"

module indexed_list_store_top #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [ils_pkg::ACT_W-1:0]   in_action,
  input  wire logic [ils_pkg::POS_W-1:0]   in_position,
  input  wire logic [ils_pkg::VAL_W-1:0]   in_value,
  output logic                             out_valid,
  output logic      [ils_pkg::STAT_W-1:0]  out_status,
  output logic      [ils_pkg::VAL_W-1:0]   out_read_value,
  output logic                             out_hit,
  output logic      [ils_pkg::POS_W-1:0]   out_hit_position,
  output logic      [ils_pkg::CNT_W-1:0]   out_entry_count,
  output logic                             out_list_empty,
  output logic                             out_is_full,
  input  wire logic                        cfg_we,
  input  wire logic [ils_pkg::CNT_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(ils_pkg::DEPTH);

  ils_pkg::state_t state_r, state_nxt;

  logic [ils_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [ils_pkg::CNT_W-1:0]  cap_r, cap_nxt;
  logic                       pend_r, pend_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [ils_pkg::ACT_W-1:0]  act_r, act_nxt;
  logic [ils_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0]      val_r, val_nxt;
  logic [ils_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]              pend_addr_r, pend_addr_nxt;
  logic [ils_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [ils_pkg::VAL_W-1:0]  rd_r, rd_nxt;
  logic                       hit_r, hit_nxt;
  logic [ils_pkg::POS_W-1:0]  hpos_r, hpos_nxt;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [DATA_WIDTH-1:0]      mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [DATA_WIDTH-1:0]      mem_rdata;

  logic [ils_pkg::CNT_W-1:0]  eff_cap;
  logic [ils_pkg::CNT_W-1:0]  pos_ext;
  logic                       accept;
  logic                       full;
  logic                       pos_bad;
  logic                       ins_issue;
  logic                       del_issue;
  logic                       find_issue;
  logic                       find_hit;
  logic                       walk_issue;
  logic                       walk_end;

  ils_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (ils_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // capacity of zero acts as one, above DEPTH acts as DEPTH
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = ils_pkg::CNT_W'(1);
    end else if (int'(cap_r) > ils_pkg::DEPTH) begin
      eff_cap = ils_pkg::CNT_W'(ils_pkg::DEPTH);
    end else begin
      eff_cap = cap_r;
    end
  end

  assign busy       = (state_r != ils_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign pos_ext    = {1'b0, pos_r};
  assign full       = (count_r >= eff_cap);
  assign pos_bad    = (pos_ext >= count_r);
  assign ins_issue  = (idx_r > pos_ext);
  assign del_issue  = (({1'b0, idx_r} + 10'd1) < {1'b0, count_r});
  assign find_issue = (idx_r < count_r);
  assign find_hit   = pend_r && (mem_rdata == val_r);

  always_comb begin
    case (act_r)
      ils_pkg::ACT_INSERT: walk_issue = ins_issue;
      ils_pkg::ACT_DELETE: walk_issue = del_issue;
      default:             walk_issue = find_issue && !find_hit;
    endcase
  end

  assign walk_end = (!walk_issue && !pend_r) || ((act_r == ils_pkg::ACT_FIND) && find_hit);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ils_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = ils_pkg::ST_EXEC;
        end
      end
      ils_pkg::ST_EXEC: begin
        case (act_r)
          ils_pkg::ACT_INSERT: state_nxt = (full || pos_bad) ? ils_pkg::ST_IDLE : ils_pkg::ST_WALK;
          ils_pkg::ACT_DELETE: state_nxt = pos_bad ? ils_pkg::ST_IDLE : ils_pkg::ST_WALK;
          ils_pkg::ACT_GET:    state_nxt = pos_bad ? ils_pkg::ST_IDLE : ils_pkg::ST_READ;
          ils_pkg::ACT_FIND:   state_nxt = ils_pkg::ST_WALK;
          default:             state_nxt = ils_pkg::ST_IDLE;
        endcase
      end
      ils_pkg::ST_WALK: begin
        if (walk_end) begin
          state_nxt = (act_r == ils_pkg::ACT_INSERT) ? ils_pkg::ST_PLACE : ils_pkg::ST_IDLE;
        end
      end
      ils_pkg::ST_PLACE: state_nxt = ils_pkg::ST_IDLE;
      ils_pkg::ST_READ:  state_nxt = ils_pkg::ST_IDLE;
      default:           state_nxt = ils_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    count_nxt     = count_r;
    cap_nxt       = cap_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    act_nxt       = act_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    pend_addr_nxt = pend_addr_r;
    status_nxt    = status_r;
    rd_nxt        = rd_r;
    hit_nxt       = hit_r;
    hpos_nxt      = hpos_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = val_r;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    case (state_r)
      ils_pkg::ST_IDLE: begin
        if (accept) begin
          act_nxt = in_action;
          pos_nxt = in_position;
          val_nxt = DATA_WIDTH'(in_value);
        end
      end
      ils_pkg::ST_EXEC: begin
        status_nxt = ils_pkg::STAT_OK;
        rd_nxt     = '0;
        hit_nxt    = 1'b0;
        hpos_nxt   = '0;
        case (act_r)
          ils_pkg::ACT_APPEND: begin
            out_valid_nxt = 1'b1;
            if (full) begin
              status_nxt = ils_pkg::STAT_OVERFLOW;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(count_r);
              count_nxt = count_r + 1'b1;
            end
          end
          ils_pkg::ACT_INSERT: begin
            if (full) begin
              status_nxt    = ils_pkg::STAT_OVERFLOW;
              out_valid_nxt = 1'b1;
            end else if (pos_bad) begin
              status_nxt    = ils_pkg::STAT_BADINDEX;
              out_valid_nxt = 1'b1;
            end else begin
              idx_nxt = count_r;
            end
          end
          ils_pkg::ACT_EDIT: begin
            out_valid_nxt = 1'b1;
            if (pos_bad) begin
              status_nxt = ils_pkg::STAT_BADINDEX;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(pos_r);
            end
          end
          ils_pkg::ACT_DELETE: begin
            if (pos_bad) begin
              status_nxt    = ils_pkg::STAT_BADINDEX;
              out_valid_nxt = 1'b1;
            end else begin
              idx_nxt = pos_ext;
            end
          end
          ils_pkg::ACT_GET: begin
            if (pos_bad) begin
              status_nxt    = ils_pkg::STAT_BADINDEX;
              out_valid_nxt = 1'b1;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(pos_r);
            end
          end
          ils_pkg::ACT_FIND: begin
            idx_nxt = '0;
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end
      ils_pkg::ST_WALK: begin
        // write back the word read last cycle, one slot up or down
        if (pend_r && (act_r != ils_pkg::ACT_FIND)) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = mem_rdata;
        end
        if (walk_issue) begin
          mem_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = AW'(idx_r);
          case (act_r)
            ils_pkg::ACT_INSERT: begin
              mem_raddr = AW'(idx_r - 1'b1);
              idx_nxt   = idx_r - 1'b1;
            end
            ils_pkg::ACT_DELETE: begin
              mem_raddr = AW'(idx_r + 1'b1);
              idx_nxt   = idx_r + 1'b1;
            end
            default: begin
              mem_raddr = AW'(idx_r);
              idx_nxt   = idx_r + 1'b1;
            end
          endcase
        end
        if ((act_r == ils_pkg::ACT_FIND) && find_hit) begin
          hit_nxt  = 1'b1;
          hpos_nxt = ils_pkg::POS_W'(pend_addr_r);
        end
        if (walk_end && (act_r != ils_pkg::ACT_INSERT)) begin
          out_valid_nxt = 1'b1;
          if (act_r == ils_pkg::ACT_DELETE) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      ils_pkg::ST_PLACE: begin
        mem_we        = 1'b1;
        mem_waddr     = AW'(pos_r);
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
      end
      ils_pkg::ST_READ: begin
        rd_nxt        = ils_pkg::VAL_W'(mem_rdata);
        out_valid_nxt = 1'b1;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase

    // capacity write empties the list
    if (cfg_we) begin
      cap_nxt   = cfg_wdata;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ils_pkg::ST_IDLE;
      count_r     <= '0;
      cap_r       <= ils_pkg::CAP_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    idx_r       <= idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    status_r    <= status_nxt;
    rd_r        <= rd_nxt;
    hit_r       <= hit_nxt;
    hpos_r      <= hpos_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_read_value   = rd_r;
  assign out_hit          = hit_r;
  assign out_hit_position = hpos_r;
  assign out_entry_count  = count_r;
  assign out_list_empty   = (count_r == '0);
  assign out_is_full      = (count_r == eff_cap);

  `ASSERT_HOLDS(a_count_in_cap, clk, rst_n, count_r <= eff_cap, "count above capacity")
  `ASSERT_IMPLIES(a_idle_no_write, clk, rst_n, state_r == ils_pkg::ST_IDLE, !mem_we, "RAM write while idle")
  `ASSERT_IMPLIES(a_walk_no_overlap, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit the same entry")
  `ASSERT_IMPLIES(a_result_after_work, clk, rst_n, out_valid, $past(state_r != ils_pkg::ST_IDLE), "result without an action in flight")

endmodule

`default_nettype wire

### dv/ils_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ils_checker
// watches the command, result and capacity ports of the indexed list store,
// keeps its own copy of the list, and scores every result against it
// ----------------------------------------------------------------------------
module ils_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [ils_pkg::ACT_W-1:0]  in_action,
  input  logic [ils_pkg::POS_W-1:0]  in_position,
  input  logic [ils_pkg::VAL_W-1:0]  in_value,
  input  logic                       out_valid,
  input  logic [ils_pkg::STAT_W-1:0] out_status,
  input  logic [ils_pkg::VAL_W-1:0]  out_read_value,
  input  logic                       out_hit,
  input  logic [ils_pkg::POS_W-1:0]  out_hit_position,
  input  logic [ils_pkg::CNT_W-1:0]  out_entry_count,
  input  logic                       out_list_empty,
  input  logic                       out_is_full,
  input  logic                       cfg_we,
  input  logic [ils_pkg::CNT_W-1:0]  cfg_wdata,
  output int                         fail_count,
  output int                         replies_owed,
  output int                         replies_checked,
  output int                         find_hits,
  output int                         overflows,
  output int                         bad_indexes
);

  localparam int LIST_DEPTH = ils_pkg::DEPTH;

  typedef struct packed {
    logic [ils_pkg::STAT_W-1:0] status;
    logic [ils_pkg::VAL_W-1:0]  read_value;
    logic                       hit;
    logic [ils_pkg::POS_W-1:0]  hit_position;
    logic [ils_pkg::CNT_W-1:0]  entry_count;
    logic                       list_empty;
    logic                       is_full;
  } list_reply_t;

  logic [ils_pkg::VAL_W-1:0] entries [LIST_DEPTH];
  int                        list_len;
  logic [ils_pkg::CNT_W-1:0] capacity_reg;
  list_reply_t               pending_replies [$];

  // zero acts as one, anything above the depth acts as the depth
  function automatic int usable_capacity();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > LIST_DEPTH) return LIST_DEPTH;
    return int'(capacity_reg);
  endfunction

  function automatic list_reply_t apply_action(logic [ils_pkg::ACT_W-1:0] act,
                                               logic [ils_pkg::POS_W-1:0] pos,
                                               logic [ils_pkg::VAL_W-1:0] val);
    list_reply_t r;
    int          lim;
    int          idx;
    r   = '0;
    lim = usable_capacity();
    case (act)
      ils_pkg::ACT_APPEND: begin
        if (list_len >= lim) begin
          r.status = ils_pkg::STAT_OVERFLOW;
        end else begin
          entries[list_len] = val;
          list_len++;
        end
      end
      ils_pkg::ACT_INSERT: begin
        // full list wins over a bad index
        if (list_len >= lim) begin
          r.status = ils_pkg::STAT_OVERFLOW;
        end else if (int'(pos) >= list_len) begin
          r.status = ils_pkg::STAT_BADINDEX;
        end else begin
          for (idx = list_len; idx > int'(pos); idx--) entries[idx] = entries[idx-1];
          entries[pos] = val;
          list_len++;
        end
      end
      ils_pkg::ACT_EDIT: begin
        if (int'(pos) >= list_len) r.status = ils_pkg::STAT_BADINDEX;
        else entries[pos] = val;
      end
      ils_pkg::ACT_DELETE: begin
        if (int'(pos) >= list_len) begin
          r.status = ils_pkg::STAT_BADINDEX;
        end else begin
          for (idx = int'(pos); idx + 1 < list_len; idx++) entries[idx] = entries[idx+1];
          list_len--;
        end
      end
      ils_pkg::ACT_GET: begin
        if (int'(pos) >= list_len) r.status = ils_pkg::STAT_BADINDEX;
        else r.read_value = entries[pos];
      end
      ils_pkg::ACT_FIND: begin
        for (idx = 0; idx < list_len && !r.hit; idx++) begin
          if (entries[idx] == val) begin
            r.hit          = 1'b1;
            r.hit_position = ils_pkg::POS_W'(idx);
          end
        end
      end
      default: ;
    endcase
    r.entry_count = ils_pkg::CNT_W'(list_len);
    r.list_empty  = (list_len == 0);
    r.is_full     = (list_len == lim);
    return r;
  endfunction

  task automatic check_field(string name, logic [ils_pkg::VAL_W-1:0] want,
                             logic [ils_pkg::VAL_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    list_reply_t exp_r;
    if (!rst_n) begin
      list_len     = 0;
      capacity_reg = ils_pkg::CAP_RESET;
      pending_replies.delete();
      replies_owed <= 0;
    end else begin
      if (cfg_we) begin
        capacity_reg = cfg_wdata;
        list_len     = 0;
      end
      // score the result before queueing a command taken on the same edge
      if (out_valid) begin
        if (pending_replies.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, status %0h count %0d",
                   $time, out_status, out_entry_count);
        end else begin
          exp_r = pending_replies.pop_front();
          replies_checked++;
          check_field("status", exp_r.status, out_status);
          check_field("read_value", exp_r.read_value, out_read_value);
          check_field("hit", exp_r.hit, out_hit);
          check_field("hit_position", exp_r.hit_position, out_hit_position);
          check_field("entry_count", exp_r.entry_count, out_entry_count);
          check_field("list_empty", exp_r.list_empty, out_list_empty);
          check_field("is_full", exp_r.is_full, out_is_full);
        end
      end
      if (start && !busy) begin
        exp_r = apply_action(in_action, in_position, in_value);
        if (exp_r.hit) find_hits++;
        if (exp_r.status == ils_pkg::STAT_OVERFLOW) overflows++;
        if (exp_r.status == ils_pkg::STAT_BADINDEX) bad_indexes++;
        pending_replies.push_back(exp_r);
      end
      replies_owed <= pending_replies.size();
    end
  end

endmodule

### dv/tb_indexed_list_store_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store_top
// drives list commands in bursts across a range of capacity settings, from
// directed corner cases to random traffic with spare codes and out-of-range positions; ils_checker scores results
// ----------------------------------------------------------------------------
module tb_indexed_list_store_top;

  localparam int LIST_DEPTH       = ils_pkg::DEPTH;
  localparam int CYCLE_LIMIT      = 3_000_000;
  localparam int SETTLE_CYCLES    = LIST_DEPTH + 8;
  localparam int NUM_PHASES       = 10;
  localparam int RANDOM_PER_PHASE = 130;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [ils_pkg::ACT_W-1:0]  in_action;
  logic [ils_pkg::POS_W-1:0]  in_position;
  logic [ils_pkg::VAL_W-1:0]  in_value;
  logic                       out_valid;
  logic [ils_pkg::STAT_W-1:0] out_status;
  logic [ils_pkg::VAL_W-1:0]  out_read_value;
  logic                       out_hit;
  logic [ils_pkg::POS_W-1:0]  out_hit_position;
  logic [ils_pkg::CNT_W-1:0]  out_entry_count;
  logic                       out_list_empty;
  logic                       out_is_full;
  logic                       cfg_we;
  logic [ils_pkg::CNT_W-1:0]  cfg_wdata;

  int fail_count;
  int replies_owed;
  int replies_checked;
  int find_hits;
  int overflows;
  int bad_indexes;

  int cycle_count;
  int items_sent;
  int capacity_writes;
  int list_len;
  int list_cap;
  int burst_left;

  indexed_list_store_top u_top (.*);
  ils_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, replies_owed);
      $display("Regression FAIL");
      $finish;
    end
  end

  // small key pool so finds hit and duplicates show up, full-width words otherwise
  function automatic logic [ils_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return '0;
      3:       return '1;
      default: return 32'hC0DE_0000 | $urandom_range(0, 7);
    endcase
  endfunction

  task automatic send_item(logic [ils_pkg::ACT_W-1:0] act, logic [ils_pkg::POS_W-1:0] pos,
                           logic [ils_pkg::VAL_W-1:0] val);
    start       <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (busy);
    items_sent++;
    // rough occupancy, used to aim positions and to fill the list to a level
    case (act)
      ils_pkg::ACT_APPEND: if (list_len < list_cap) list_len++;
      ils_pkg::ACT_INSERT: if (list_len < list_cap && int'(pos) < list_len) list_len++;
      ils_pkg::ACT_DELETE: if (int'(pos) < list_len) list_len--;
      default: ;
    endcase
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (replies_owed != 0 || busy);
  endtask

  task automatic write_capacity(logic [ils_pkg::CNT_W-1:0] v);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    capacity_writes++;
    list_len = 0;
    list_cap = (v == 0) ? 1 : ((v > LIST_DEPTH) ? LIST_DEPTH : int'(v));
  endtask

  task automatic pace(bit steady);
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_gap($urandom_range(1, 12));
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic random_item();
    int                        r;
    logic [ils_pkg::ACT_W-1:0] act;
    logic [ils_pkg::POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 22)      act = ils_pkg::ACT_APPEND;
    else if (r < 37) act = ils_pkg::ACT_INSERT;
    else if (r < 49) act = ils_pkg::ACT_EDIT;
    else if (r < 63) act = ils_pkg::ACT_DELETE;
    else if (r < 78) act = ils_pkg::ACT_GET;
    else if (r < 93) act = ils_pkg::ACT_FIND;
    else             act = ils_pkg::ACT_W'($urandom_range(0, 7));
    if (r >= 93 || list_len == 0) pos = ils_pkg::POS_W'($urandom);
    else if (r % 5 == 0)          pos = ils_pkg::POS_W'(list_len - 1);
    else                          pos = ils_pkg::POS_W'($urandom_range(0, list_len - 1));
    send_item(act, pos, pick_value());
  endtask

  function automatic logic [ils_pkg::CNT_W-1:0] phase_capacity(int p);
    case (p)
      0:       return 9'd4;
      1:       return 9'd511;
      2:       return 9'd1;
      3:       return 9'd0;
      4:       return 9'd256;
      5:       return 9'd20;
      6:       return 9'd2;
      7:       return 9'd300;
      8:       return 9'd64;
      default: return ils_pkg::CNT_W'($urandom_range(1, LIST_DEPTH));
    endcase
  endfunction

  initial begin
    int  level;
    bit  steady;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_action   = '0;
    in_position = '0;
    in_value    = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    list_len    = 0;
    list_cap    = LIST_DEPTH;
    burst_left  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, then shifts, duplicate keys, edges of the index range
    send_item(ils_pkg::ACT_DELETE, 8'd0, 32'h0);
    send_item(ils_pkg::ACT_FIND, 8'd0, 32'h0);
    send_item(ils_pkg::ACT_INSERT, 8'd0, 32'h1111_1111);
    send_item(ils_pkg::ACT_APPEND, 8'd0, 32'hFFFF_FFFF);
    send_item(ils_pkg::ACT_APPEND, 8'd255, 32'h0000_0000);
    send_item(ils_pkg::ACT_INSERT, 8'd0, 32'h1234_5678);
    send_item(ils_pkg::ACT_INSERT, 8'd2, 32'hFFFF_FFFF);
    send_item(ils_pkg::ACT_FIND, 8'd0, 32'hFFFF_FFFF);
    send_item(ils_pkg::ACT_EDIT, 8'd3, 32'hDEAD_BEEF);
    send_item(ils_pkg::ACT_GET, 8'd3, 32'h0);
    send_item(ils_pkg::ACT_GET, 8'd255, 32'h0);
    send_item(ils_pkg::ACT_DELETE, 8'd3, 32'h0);
    send_item(ils_pkg::ACT_DELETE, 8'd0, 32'h0);
    send_item(ils_pkg::ACT_SPARE_LO, 8'd1, 32'hFFFF_FFFF);
    send_item(ils_pkg::ACT_SPARE_HI, 8'd255, 32'h0);

    // overflow, including an insert whose index is also out of range
    write_capacity(9'd2);
    send_item(ils_pkg::ACT_APPEND, 8'd0, 32'hA5A5_5A5A);
    send_item(ils_pkg::ACT_APPEND, 8'd0, 32'h5A5A_A5A5);
    send_item(ils_pkg::ACT_APPEND, 8'd0, 32'h0F0F_0F0F);
    send_item(ils_pkg::ACT_INSERT, 8'd200, 32'h0);
    send_item(ils_pkg::ACT_DELETE, 8'd1, 32'h0);
    send_item(ils_pkg::ACT_GET, 8'd1, 32'h0);

    // capacity zero behaves as one
    write_capacity(9'd0);
    send_item(ils_pkg::ACT_APPEND, 8'd0, 32'h8000_0001);
    send_item(ils_pkg::ACT_APPEND, 8'd0, 32'h7FFF_FFFE);
    send_item(ils_pkg::ACT_DELETE, 8'd0, 32'h0);
    send_item(ils_pkg::ACT_DELETE, 8'd0, 32'h0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_capacity(p));
      steady = (p % 3 == 2);
      level  = (p == 1) ? list_cap : $urandom_range(0, list_cap);
      while (list_len < level) begin
        send_item(ils_pkg::ACT_APPEND, ils_pkg::POS_W'($urandom), pick_value());
        pace(steady);
      end
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        random_item();
        pace(steady);
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d commands over %0d capacity settings, %0d results checked",
             items_sent, capacity_writes, replies_checked);
    $display("%0d find hits, %0d overflows, %0d invalid-index replies",
             find_hits, overflows, bad_indexes);
    if (fail_count == 0 && replies_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/ils_pkg.sv
sv/ils_ram.sv
sv/indexed_list_store_top.sv
dv/ils_checker.sv
dv/tb_indexed_list_store_top.sv
